// ===== src/fragment_reassembler_top_assert.svh =====
// Assertion macros for the fragment reassembler.
// Each macro expands to a labeled concurrent assertion in simulation
// and to nothing in synthesis.
`ifndef FRAGMENT_REASSEMBLER_TOP_ASSERT_SVH
`define FRAGMENT_REASSEMBLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define FR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define FR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/fr_pkg.sv =====
package fr_pkg;

  localparam logic [7:0] HEADER_MARK = 8'h83;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ABANDON = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_HEADER  = 2'd1,
    MODE_PAYLOAD = 2'd2,
    MODE_WAIT    = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first_of_packet;
    logic       last_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [15:0] byte_index;
    logic        message_last;
  } out_item_t;

endpackage

// ===== src/fr_in_reg.sv =====
// Input register: holds one accepted byte until the engine consumes it.
module fr_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fr_pkg::in_item_t in_item,
  input  logic            advance,
  output logic            s1_valid,
  output fr_pkg::in_item_t s1_item
);

  logic             valid_r;
  logic             valid_nxt;
  fr_pkg::in_item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== src/fr_engine.sv =====
// Per-byte reassembly state and result decode.
`include "fragment_reassembler_top_assert.svh"

module fr_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  fr_pkg::in_item_t  item,
  output logic              res_valid,
  output fr_pkg::out_item_t res_item
);

  fr_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]    pos_r, pos_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [15:0]   cnt_r, cnt_nxt;
  logic [7:0]    slot_r, slot_nxt;

  logic        in_msg;
  logic        slot_match;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;
  logic        done;

  assign in_msg     = (mode_r == fr_pkg::MODE_PAYLOAD) || (mode_r == fr_pkg::MODE_WAIT);
  assign slot_match = (item.data == slot_r);
  assign len_full   = {len_r[15:8], item.data};
  assign cnt_inc    = cnt_r + 16'd1;
  assign done       = (cnt_inc == len_r);

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    slot_nxt = slot_r;
    if (item.first_of_packet) begin
      if (in_msg && slot_match) begin
        mode_nxt = fr_pkg::MODE_PAYLOAD;
        slot_nxt = slot_r + 8'd1;
      end else if (item.data == fr_pkg::HEADER_MARK) begin
        mode_nxt = fr_pkg::MODE_HEADER;
        len_nxt  = '0;
        cnt_nxt  = '0;
      end else begin
        mode_nxt = fr_pkg::MODE_IDLE;
      end
      pos_nxt = 2'd1;
    end else begin
      case (mode_r)
        fr_pkg::MODE_HEADER: begin
          if (pos_r == 2'd1) begin
            len_nxt = {item.data, 8'h00};
          end else begin
            len_nxt  = len_full;
            cnt_nxt  = '0;
            slot_nxt = '0;
            mode_nxt = (len_full == 16'd0) ? fr_pkg::MODE_IDLE : fr_pkg::MODE_PAYLOAD;
          end
        end
        fr_pkg::MODE_PAYLOAD: begin
          cnt_nxt = cnt_inc;
          if (done) begin
            mode_nxt = fr_pkg::MODE_IDLE;
          end
        end
        default: begin
        end
      endcase
      if (pos_r != 2'd3) begin
        pos_nxt = pos_r + 2'd1;
      end
    end
    if (item.last_of_packet) begin
      if (mode_nxt == fr_pkg::MODE_HEADER) begin
        mode_nxt = fr_pkg::MODE_IDLE;
      end else if (mode_nxt == fr_pkg::MODE_PAYLOAD) begin
        mode_nxt = fr_pkg::MODE_WAIT;
      end
      pos_nxt = 2'd0;
    end
  end

  // Result decode
  always_comb begin
    res_valid = 1'b0;
    res_item  = '0;
    if (item.first_of_packet) begin
      if (in_msg && !slot_match) begin
        res_valid     = 1'b1;
        res_item.kind = fr_pkg::KIND_ABANDON;
      end
    end else begin
      case (mode_r)
        fr_pkg::MODE_HEADER: begin
          if (pos_r != 2'd1 && len_full == 16'd0) begin
            res_valid     = 1'b1;
            res_item.kind = fr_pkg::KIND_EMPTY;
          end
        end
        fr_pkg::MODE_PAYLOAD: begin
          res_valid             = 1'b1;
          res_item.kind         = fr_pkg::KIND_PAYLOAD;
          res_item.payload      = item.data;
          res_item.byte_index   = cnt_r;
          res_item.message_last = done;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fr_pkg::MODE_IDLE;
      pos_r  <= '0;
      len_r  <= '0;
      cnt_r  <= '0;
      slot_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      slot_r <= slot_nxt;
    end
  end

  // A live message always has room left before its declared length.
  `FR_ASSERT_IMPLY(a_cnt_below_len, clk, rst_n, in_msg, cnt_r < len_r, "count reached length in message")
  // Header parsing only ever sits between the marker and the low length byte.
  `FR_ASSERT_IMPLY(a_hdr_pos, clk, rst_n, mode_r == fr_pkg::MODE_HEADER, pos_r == 2'd1 || pos_r == 2'd2, "header at bad byte position")
  // A payload result only comes out of payload mode on a non-first byte.
  `FR_ASSERT_IMPLY(a_payload_src, clk, rst_n, res_valid && res_item.kind == fr_pkg::KIND_PAYLOAD, mode_r == fr_pkg::MODE_PAYLOAD && !item.first_of_packet, "payload result outside payload mode")

endmodule

// ===== src/fr_out_reg.sv =====
// Result register: holds one result transaction until the consumer takes it.
module fr_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  fr_pkg::out_item_t res_item,
  output logic              slot_free,
  input  logic              out_ready,
  output logic              out_valid,
  output fr_pkg::out_item_t out_item
);

  logic              valid_r;
  logic              valid_nxt;
  fr_pkg::out_item_t item_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ===== src/fragment_reassembler_top.sv =====
// Fragment reassembler: one link byte per transaction in, at most one result out.
// A byte waits in the input register; the engine is combinational; its result is held in the result register.
// Throughput: 1 byte per cycle while out_ready is high; the state update is a single pass.
// Reset: synchronous active-low rst_n empties both registers and returns to idle.
// The result register frees and reloads in the same cycle, so there is no bubble.
module fragment_reassembler_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fr_pkg::in_item_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output fr_pkg::out_item_t out_item
);

  logic              s1_valid;
  fr_pkg::in_item_t  s1_item;
  logic              slot_free;
  logic              advance;
  logic              res_valid;
  fr_pkg::out_item_t res_item;

  // The held byte moves through the engine once the result register can take
  // whatever it produces; bytes with no result still wait for that slot.
  assign advance = s1_valid && slot_free;

  fr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Packet parsing, slot tracking and the payload counter live here.
  fr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (s1_item),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  fr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res_item  (res_item),
    .slot_free (slot_free),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
